// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define BBC_ASSERT(name, clk, rst_n, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// same-cycle implication
`define BBC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bbc_pkg.sv =====
package bbc_pkg;

  // cache geometry
  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CMP_W   = (IDX_W > 5) ? IDX_W : 5;

  // command codes
  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_MARK    = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  // status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // update broadcast to the cells
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_HIT     = 3'd1,
    OP_CLAIM   = 3'd2,
    OP_RELEASE = 3'd3,
    OP_MARK    = 3'd4
  } op_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  device_number;
    logic [31:0] block_number;
    logic [4:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [4:0] result_index;
    logic [1:0] status;
    logic       was_hit;
    logic       data_valid;
  } rsp_t;

  // running search result passed down the cell row
  typedef struct packed {
    logic             hit_found;
    logic [IDX_W-1:0] hit_rank;
    logic [IDX_W-1:0] hit_idx;
    logic             hit_valid;
    logic             free_found;
    logic [IDX_W-1:0] free_rank;
    logic [IDX_W-1:0] free_idx;
    logic             tgt_found;
    logic [7:0]       tgt_cnt;
    logic             tgt_valid;
    logic [IDX_W-1:0] tgt_rank;
  } carry_t;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] target;
    logic [IDX_W-1:0] rank;
    logic             move;
    logic [7:0]       dev;
    logic [31:0]      blk;
  } apply_t;

  localparam carry_t CARRY_EMPTY = '0;

endpackage

// ===== rtl/bbc_cell.sv =====
`include "assert_macros.svh"

module bbc_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [bbc_pkg::IDX_W-1:0] my_idx_i,
  input  logic [bbc_pkg::IDX_W-1:0] reset_rank_i,
  input  logic                  clr_i,
  input  bbc_pkg::req_t         key_i,
  input  bbc_pkg::carry_t       carry_i,
  output bbc_pkg::carry_t       carry_o,
  input  bbc_pkg::apply_t       apply_i
);
  import bbc_pkg::*;

  logic [7:0]       dev_q, dev_d;
  logic [31:0]      blk_q, blk_d;
  logic             valid_q, valid_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0] rank_q, rank_d;
  carry_t           carry_q, carry_d;
  logic             match;
  logic             sel;

  // merge own entry into the running search result; clr_i empties it
  always_comb begin
    match   = (dev_q == key_i.device_number) && (blk_q == key_i.block_number);
    carry_d = carry_i;
    if (match && (!carry_i.hit_found || rank_q < carry_i.hit_rank)) begin
      carry_d.hit_found = 1'b1;
      carry_d.hit_rank  = rank_q;
      carry_d.hit_idx   = my_idx_i;
      carry_d.hit_valid = valid_q;
    end
    if ((cnt_q == 8'd0) && (!carry_i.free_found || rank_q > carry_i.free_rank)) begin
      carry_d.free_found = 1'b1;
      carry_d.free_rank  = rank_q;
      carry_d.free_idx   = my_idx_i;
    end
    if (CMP_W'(key_i.entry_index) == CMP_W'(my_idx_i)) begin
      carry_d.tgt_found = 1'b1;
      carry_d.tgt_cnt   = cnt_q;
      carry_d.tgt_valid = valid_q;
      carry_d.tgt_rank  = rank_q;
    end
    if (clr_i) begin
      carry_d = CARRY_EMPTY;
    end
  end

  // entry update from the broadcast
  always_comb begin
    sel     = (apply_i.target == my_idx_i);
    dev_d   = dev_q;
    blk_d   = blk_q;
    valid_d = valid_q;
    cnt_d   = cnt_q;
    rank_d  = rank_q;
    case (apply_i.op)
      OP_HIT: begin
        if (sel && cnt_q != 8'hFF) cnt_d = cnt_q + 8'd1;
      end
      OP_CLAIM: begin
        if (sel) begin
          dev_d   = apply_i.dev;
          blk_d   = apply_i.blk;
          valid_d = 1'b0;
          cnt_d   = 8'd1;
        end
      end
      OP_RELEASE: begin
        if (sel) cnt_d = cnt_q - 8'd1;
        if (apply_i.move) begin
          if (sel) begin
            rank_d = '0;
          end else if (rank_q < apply_i.rank) begin
            rank_d = rank_q + IDX_W'(1);
          end
        end
      end
      OP_MARK: begin
        if (sel) valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // entry and carry registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q   <= '0;
      blk_q   <= '0;
      valid_q <= 1'b0;
      cnt_q   <= '0;
      rank_q  <= reset_rank_i;
      carry_q <= CARRY_EMPTY;
    end else begin
      dev_q   <= dev_d;
      blk_q   <= blk_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      rank_q  <= rank_d;
      carry_q <= carry_d;
    end
  end

  assign carry_o = carry_q;

  // count and order move only on the matching update
  `BBC_ASSERT_NXT(a_cnt_hold, clk_i, rst_ni, apply_i.op == OP_NONE, $stable(cnt_q), "count changed without update")
  `BBC_ASSERT_NXT(a_rank_hold, clk_i, rst_ni, apply_i.op != OP_RELEASE, $stable(rank_q), "rank changed outside release")
  `BBC_ASSERT_IMP(a_rel_nonzero, clk_i, rst_ni, apply_i.op == OP_RELEASE && sel, cnt_q != 8'd0, "release of empty count applied")

endmodule

// ===== rtl/block_buffer_cache_lru_top.sv =====
// sequencing: one transaction at a time; a new one is taken only in idle, after the
//   update of the last, as the search carry walks the cell row one cell per cycle
//   before the update cycle, which waits while the output is stalled
// reset: asynchronous active low; all tags, marks and counts clear, highest
//   entry most recent, no clearing pass so the block takes input right after reset
`include "assert_macros.svh"

module block_buffer_cache_lru_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bbc_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bbc_pkg::rsp_t out_data_o
);
  import bbc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_APPLY  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  req_t             req_q;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_data_q, out_data_d;
  logic             accept;
  logic             advance;
  apply_t           apply;
  carry_t           carry [ENTRIES];
  carry_t           res;

  assign accept  = in_valid_i && !in_stall_o;
  assign advance = (state_q == S_APPLY) && (!out_valid_q || !out_stall_i);
  assign res     = carry[ENTRIES-1];

  // cell row
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    bbc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .my_idx_i     (IDX_W'(i)),
      .reset_rank_i (IDX_W'(ENTRIES - 1 - i)),
      .clr_i        (accept),
      .key_i        (req_q),
      .carry_i      ((i == 0) ? CARRY_EMPTY : carry[(i == 0) ? 0 : i - 1]),
      .carry_o      (carry[i]),
      .apply_i      (apply)
    );
  end

  // decide the update and the result from the finished search
  always_comb begin
    apply              = '0;
    apply.op           = OP_NONE;
    apply.dev          = req_q.device_number;
    apply.blk          = req_q.block_number;
    out_data_d.result_index = req_q.entry_index;
    out_data_d.status       = ST_OK;
    out_data_d.was_hit      = 1'b0;
    out_data_d.data_valid   = 1'b0;
    if (req_q.command == CMD_ACQUIRE) begin
      if (res.hit_found) begin
        apply.op                = OP_HIT;
        apply.target            = res.hit_idx;
        out_data_d.result_index = 5'(res.hit_idx);
        out_data_d.was_hit      = 1'b1;
        out_data_d.data_valid   = res.hit_valid;
      end else if (res.free_found) begin
        apply.op                = OP_CLAIM;
        apply.target            = res.free_idx;
        out_data_d.result_index = 5'(res.free_idx);
      end else begin
        out_data_d.result_index = '0;
        out_data_d.status       = ST_NO_FREE;
      end
    end else if (res.tgt_found) begin
      apply.target          = IDX_W'(req_q.entry_index);
      out_data_d.data_valid = res.tgt_valid;
      case (req_q.command)
        CMD_RELEASE: begin
          if (res.tgt_cnt == 8'd0) begin
            out_data_d.status = ST_UNDERFLOW;
          end else begin
            apply.op   = OP_RELEASE;
            apply.move = (res.tgt_cnt == 8'd1);
            apply.rank = res.tgt_rank;
          end
        end
        CMD_MARK: begin
          apply.op              = OP_MARK;
          out_data_d.data_valid = 1'b1;
        end
        default: ;
      endcase
    end
    if (!advance) apply.op = OP_NONE;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SEARCH;
          cnt_d   = '0;
        end
      end
      S_SEARCH: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_W'(ENTRIES - 1)) state_d = S_APPLY;
      end
      S_APPLY: begin
        if (advance) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (advance) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_data_i;
    if (advance) out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `BBC_ASSERT_NXT(a_accept_search, clk_i, rst_ni, accept, state_q == S_SEARCH && cnt_q == '0, "accepted transaction did not start search")
  `BBC_ASSERT_IMP(a_out_from_apply, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_APPLY), "result without update cycle")
  `BBC_ASSERT_IMP(a_update_only_apply, clk_i, rst_ni, apply.op != OP_NONE, state_q == S_APPLY, "update outside update cycle")

endmodule

// ===== bench/block_buffer_cache_lru_top_test.sv =====
`timescale 1ns / 1ps

module block_buffer_cache_lru_top_test;
  import bbc_pkg::*;

  localparam int POOL_SIZE   = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN       = ENTRIES + 10;
  localparam int RANDOM_ITEMS = 880;
  localparam int SAT_BURST   = 257;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;

  block_buffer_cache_lru_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // two copies of the tag store: 0 plans the stimulus, 1 predicts at acceptance
  logic [7:0]  tag_dev  [2][ENTRIES];
  logic [31:0] tag_blk  [2][ENTRIES];
  logic        fill_ok  [2][ENTRIES];
  logic [7:0]  users    [2][ENTRIES];
  int unsigned lru_pos  [2][ENTRIES];

  req_t pending_req[$];
  rsp_t expected_rsp[$];

  logic [7:0]  pool_dev [POOL_SIZE];
  logic [31:0] pool_blk [POOL_SIZE];

  int unsigned sent_cnt = 0;
  int unsigned got_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        hold_active;
  int unsigned phase;
  rsp_t        want;

  assign hold_active = (hold_left != 0);
  assign phase = (sent_cnt / 100) % 4;

  // percentage of cycles a side spends idle in the current phase
  function automatic int unsigned idle_pct(input int unsigned ph, input bit rx_side);
    case (ph)
      1: return rx_side ? 0 : 72;
      2: return rx_side ? 72 : 0;
      3: return 12;
      default: return 0;
    endcase
  endfunction

  // apply one request to store copy c and return the response it gives
  function automatic rsp_t cache_access(input int c, input req_t rq);
    rsp_t rs;
    int best;
    bit found;
    int unsigned pos;
    rs = '0;
    best = 0;
    found = 1'b0;
    if (rq.command == CMD_ACQUIRE) begin
      // hit search, most recent first
      for (int i = 0; i < ENTRIES; i++) begin
        if (tag_dev[c][i] == rq.device_number && tag_blk[c][i] == rq.block_number &&
            (!found || lru_pos[c][i] < lru_pos[c][best])) begin
          best = i;
          found = 1'b1;
        end
      end
      if (found) begin
        if (users[c][best] != 8'd255) users[c][best] = users[c][best] + 8'd1;
        rs.result_index = 5'(best);
        rs.status = ST_OK;
        rs.was_hit = 1'b1;
        rs.data_valid = fill_ok[c][best];
        return rs;
      end
      // victim search, least recent unreferenced entry
      for (int i = 0; i < ENTRIES; i++) begin
        if (users[c][i] == 8'd0 && (!found || lru_pos[c][i] > lru_pos[c][best])) begin
          best = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        rs.status = ST_NO_FREE;
        return rs;
      end
      tag_dev[c][best] = rq.device_number;
      tag_blk[c][best] = rq.block_number;
      fill_ok[c][best] = 1'b0;
      users[c][best] = 8'd1;
      rs.result_index = 5'(best);
      rs.status = ST_OK;
      return rs;
    end
    rs.result_index = rq.entry_index;
    rs.status = ST_OK;
    if (int'(rq.entry_index) >= ENTRIES) return rs;
    best = int'(rq.entry_index);
    if (rq.command == CMD_RELEASE) begin
      if (users[c][best] == 8'd0) begin
        rs.status = ST_UNDERFLOW;
      end else begin
        users[c][best] = users[c][best] - 8'd1;
        // last reference gone: entry becomes most recent
        if (users[c][best] == 8'd0) begin
          pos = lru_pos[c][best];
          for (int i = 0; i < ENTRIES; i++) begin
            if (lru_pos[c][i] < pos) lru_pos[c][i] = lru_pos[c][i] + 1;
          end
          lru_pos[c][best] = 0;
        end
      end
    end else if (rq.command == CMD_MARK) begin
      fill_ok[c][best] = 1'b1;
    end
    rs.data_valid = fill_ok[c][best];
    return rs;
  endfunction

  // append a request and advance the planning copy
  task automatic queue_item(input cmd_e cmd, input logic [7:0] dev, input logic [31:0] blk,
                            input logic [4:0] idx);
    req_t rq;
    rq.command = cmd;
    rq.device_number = dev;
    rq.block_number = blk;
    rq.entry_index = idx;
    pending_req.push_back(rq);
    void'(cache_access(0, rq));
  endtask

  // clock and reset
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // stimulus generation, then wait for the drain
  initial begin
    int unsigned r;
    int unsigned p_acq;
    int unsigned p_rel;
    int k;
    int held[$];
    cmd_e cmd;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [4:0]  idx;

    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag_dev[c][i] = '0;
        tag_blk[c][i] = '0;
        fill_ok[c][i] = 1'b0;
        users[c][i] = '0;
        lru_pos[c][i] = ENTRIES - 1 - i;
      end
    end
    pool_dev[0] = 8'h00;
    pool_blk[0] = 32'h0;
    for (int i = 1; i < POOL_SIZE; i++) begin
      pool_dev[i] = 8'($urandom);
      pool_blk[i] = $urandom;
    end

    // directed: reset tags hit, underflow, unused command, bit extremes
    queue_item(CMD_ACQUIRE, 8'h00, 32'h0000_0000, 5'd0);
    queue_item(CMD_ACQUIRE, 8'h00, 32'h0000_0000, 5'd31);
    queue_item(CMD_MARK,    8'hff, 32'hffff_ffff, 5'd31);
    queue_item(CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd31);
    queue_item(CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd31);
    queue_item(CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd31);
    queue_item(CMD_UNUSED,  8'h00, 32'h0000_0000, 5'd31);
    queue_item(CMD_ACQUIRE, 8'hff, 32'hffff_ffff, 5'd31);
    queue_item(CMD_ACQUIRE, 8'haa, 32'h5555_5555, 5'd10);
    queue_item(CMD_ACQUIRE, 8'h55, 32'haaaa_aaaa, 5'd21);
    queue_item(CMD_MARK,    8'h00, 32'h0000_0000, 5'd0);
    queue_item(CMD_ACQUIRE, 8'hff, 32'hffff_ffff, 5'd0);
    queue_item(CMD_RELEASE, 8'hff, 32'hffff_ffff, 5'd0);
    queue_item(CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd0);
    queue_item(CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd0);
    queue_item(CMD_UNUSED,  8'hff, 32'hffff_ffff, 5'd0);
    queue_item(CMD_MARK,    8'h00, 32'h0000_0000, 5'd15);
    queue_item(CMD_UNUSED,  8'h00, 32'h0000_0000, 5'd15);
    queue_item(CMD_ACQUIRE, 8'h00, 32'h0000_0000, 5'd0);

    // count saturation on one hot block
    dev = 8'h3c;
    blk = $urandom;
    for (int n = 0; n < SAT_BURST; n++) queue_item(CMD_ACQUIRE, dev, blk, 5'($urandom));

    // random traffic, alternating acquire-heavy and release-heavy stretches
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      p_acq = ((n / 110) % 2 == 0) ? 68 : 30;
      p_rel = ((n / 110) % 2 == 0) ? 22 : 55;
      r = $urandom_range(0, 99);
      dev = 8'($urandom);
      blk = $urandom;
      idx = 5'($urandom_range(0, 31));
      held.delete();
      for (int i = 0; i < ENTRIES; i++) begin
        if (users[0][i] != 8'd0) held.push_back(i);
      end
      if (r < p_acq) begin
        cmd = CMD_ACQUIRE;
        if ($urandom_range(0, 4) != 0) begin
          k = $urandom_range(0, POOL_SIZE - 1);
          dev = pool_dev[k];
          blk = pool_blk[k];
        end
      end else if (r < p_acq + p_rel) begin
        cmd = CMD_RELEASE;
        if (held.size() != 0 && $urandom_range(0, 99) < 85)
          idx = 5'(held[$urandom_range(0, held.size() - 1)]);
      end else if (r < 97) begin
        cmd = CMD_MARK;
        if (held.size() != 0 && $urandom_range(0, 99) < 70)
          idx = 5'(held[$urandom_range(0, held.size() - 1)]);
      end else begin
        cmd = CMD_UNUSED;
      end
      queue_item(cmd, dev, blk, idx);
    end

    // drain: checked away from the clock edge to avoid races
    @(posedge rst_ni);
    while (pending_req.size() != 0 || in_valid_i || expected_rsp.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
    if (mismatch_cnt == 0 && expected_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // driver: predict on each accepted transaction, offer the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_rsp.push_back(cache_access(1, in_data_i));
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_req.size() != 0 &&
            (hold_active || $urandom_range(0, 99) >= idle_pct(phase, 1'b0))) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_req.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted transaction with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_cnt <= got_cnt + 1;
        if (expected_rsp.size() == 0) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10)
            $display("unexpected response: idx %0d status %0d hit %0b valid %0b",
                     out_data_o.result_index, out_data_o.status, out_data_o.was_hit,
                     out_data_o.data_valid);
        end else begin
          want = expected_rsp.pop_front();
          if (out_data_o.result_index !== want.result_index ||
              out_data_o.status !== want.status ||
              out_data_o.was_hit !== want.was_hit ||
              out_data_o.data_valid !== want.data_valid) begin
            mismatch_cnt = mismatch_cnt + 1;
            if (mismatch_cnt <= 10)
              $display("mismatch at response %0d: exp idx %0d status %0d hit %0b valid %0b, got idx %0d status %0d hit %0b valid %0b",
                       got_cnt, want.result_index, want.status, want.was_hit,
                       want.data_valid, out_data_o.result_index, out_data_o.status,
                       out_data_o.was_hit, out_data_o.data_valid);
          end
        end
      end
      out_stall_i <= hold_active || ($urandom_range(0, 99) < idle_pct(phase, 1'b1));
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && got_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bbc_pkg.sv
rtl/bbc_cell.sv
rtl/block_buffer_cache_lru_top.sv
bench/block_buffer_cache_lru_top_test.sv
